// File: rtl/core/tfd_pkg.sv
// Package for the tagged frame deframer: types, widths and the start tag table.
`timescale 1ns / 1ps
`default_nettype none

package tfd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned TagCntW   = 4;
  localparam int unsigned HdrCntW   = 6;
  localparam int unsigned SizeW     = 32;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TRAILER = 2'd3
  } phase_e;

  // Byte held in the input register.
  typedef struct packed {
    logic              valid;
    logic [ByteW-1:0]  data;
  } in_item_t;

  // Result produced by the core for one byte.
  typedef struct packed {
    logic              valid;
    logic [ByteW-1:0]  data;
    logic              last;
  } res_t;

  // Start tag "BoundaryS"; positions past the ninth expect 0x00.
  function automatic logic [ByteW-1:0] tag_byte(input logic [TagCntW-1:0] idx);
    logic [ByteW-1:0] b;
    b = 8'h00;
    unique case (idx)
      4'd0:    b = 8'h42; // B
      4'd1:    b = 8'h6F; // o
      4'd2:    b = 8'h75; // u
      4'd3:    b = 8'h6E; // n
      4'd4:    b = 8'h64; // d
      4'd5:    b = 8'h61; // a
      4'd6:    b = 8'h72; // r
      4'd7:    b = 8'h79; // y
      4'd8:    b = 8'h53; // S
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tagged_frame_deframer.sv
// Top level of the tagged frame deframer.
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream deframer. Each input transaction carries one raw byte. The block
// hunts for the start tag "BoundaryS" (TAG_LEN bytes; positions past the ninth
// expect 0x00), reads a HEADER_LEN-byte header whose bytes 4..7 give the
// payload size little-endian, then emits each payload byte as one output
// transaction, with the byte at index size/2 inverted and frame_last_o set on
// the final byte. TAG_LEN trailer bytes are then dropped unchecked and hunting
// resumes; a zero-size frame emits nothing. A mismatching tag byte is retried
// as a first tag byte. While out_ready_i is high, throughput is one byte per
// clock: an input register feeds the per-byte state update and a result
// register holds the output. While a result waits, the input register takes
// one byte and holds it. in_ready_o drops only when the input register and
// the result register are both full and out_ready_i is low. Bytes that
// produce no result still pass through the input register in order.

module tagged_frame_deframer #(
  parameter int unsigned TAG_LEN    = 9,
  parameter int unsigned HEADER_LEN = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [tfd_pkg::ByteW-1:0]  in_byte_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [tfd_pkg::ByteW-1:0]       out_byte_o,
  output logic                            frame_last_o
);

  tfd_pkg::in_item_t item;
  tfd_pkg::res_t     res;
  logic              slot_free;
  logic              advance;

  // The held byte moves into the core once the result slot can take its result.
  assign advance = item.valid && slot_free;

  tfd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .advance_i  (advance),
    .item_o     (item)
  );

  tfd_core #(
    .TAG_LEN    (TAG_LEN),
    .HEADER_LEN (HEADER_LEN)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .advance_i (advance),
    .res_o     (res)
  );

  tfd_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .res_i        (res),
    .slot_free_o  (slot_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .frame_last_o (frame_last_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/tfd_in_stage.sv
// Input register of the deframer: holds one byte until the core takes it.
`timescale 1ns / 1ps
`default_nettype none

module tfd_in_stage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [tfd_pkg::ByteW-1:0]   in_byte_i,
  input  wire logic                        advance_i,
  output tfd_pkg::in_item_t                item_o
);

  logic                      valid_q, valid_d;
  logic [tfd_pkg::ByteW-1:0] data_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_byte_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.data  = data_q;

endmodule

`default_nettype wire

// File: rtl/core/tfd_core.sv
// Deframer state machine: tag hunt, header parse, payload pass, trailer skip.
`timescale 1ns / 1ps
`default_nettype none

module tfd_core #(
  parameter int unsigned TAG_LEN    = 9,
  parameter int unsigned HEADER_LEN = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tfd_pkg::in_item_t  item_i,
  input  wire logic               advance_i,
  output tfd_pkg::res_t           res_o
);

  tfd_pkg::phase_e                 phase_q, phase_d;
  logic [tfd_pkg::TagCntW-1:0]     tag_cnt_q, tag_cnt_d;
  logic [tfd_pkg::HdrCntW-1:0]     hdr_cnt_q, hdr_cnt_d;
  logic [tfd_pkg::SizeW-1:0]       size_q, size_d;
  logic [tfd_pkg::SizeW-1:0]       pay_cnt_q, pay_cnt_d;
  logic [tfd_pkg::TagCntW-1:0]     trl_cnt_q, trl_cnt_d;

  logic [tfd_pkg::ByteW-1:0]       b;
  logic [tfd_pkg::TagCntW-1:0]     tag_inc;
  logic [tfd_pkg::HdrCntW-1:0]     hdr_inc;
  logic [tfd_pkg::TagCntW-1:0]     trl_inc;
  logic                            is_last;
  logic                            is_mid;

  assign b       = item_i.data;
  assign tag_inc = tag_cnt_q + 4'd1;
  assign hdr_inc = hdr_cnt_q + 6'd1;
  assign trl_inc = trl_cnt_q + 4'd1;
  assign is_last = (pay_cnt_q == (size_q - 32'd1));
  assign is_mid  = (pay_cnt_q == {1'b0, size_q[tfd_pkg::SizeW-1:1]});

  always_comb begin
    phase_d    = phase_q;
    tag_cnt_d  = tag_cnt_q;
    hdr_cnt_d  = hdr_cnt_q;
    size_d     = size_q;
    pay_cnt_d  = pay_cnt_q;
    trl_cnt_d  = trl_cnt_q;
    res_o.valid = 1'b0;
    res_o.data  = b;
    res_o.last  = 1'b0;

    unique case (phase_q)
      tfd_pkg::PH_HUNT: begin
        if (b == tfd_pkg::tag_byte(tag_cnt_q)) begin
          tag_cnt_d = tag_inc;
          if (tag_inc == 4'(TAG_LEN)) begin
            tag_cnt_d = '0;
            hdr_cnt_d = '0;
            phase_d   = tfd_pkg::PH_HEADER;
          end
        end else begin
          // retry the byte as a first tag byte
          tag_cnt_d = (b == tfd_pkg::tag_byte('0)) ? 4'd1 : 4'd0;
        end
      end
      tfd_pkg::PH_HEADER: begin
        // bytes 4..7 carry the size, little-endian
        if (hdr_cnt_q[5:2] == 4'd1) begin
          for (int k = 0; k < 4; k++) begin
            if (hdr_cnt_q[1:0] == 2'(k)) begin
              size_d[k*8 +: 8] = b;
            end
          end
        end
        hdr_cnt_d = hdr_inc;
        if (hdr_inc == 6'(HEADER_LEN)) begin
          hdr_cnt_d = '0;
          pay_cnt_d = '0;
          trl_cnt_d = '0;
          phase_d   = (size_d == '0) ? tfd_pkg::PH_TRAILER : tfd_pkg::PH_PAYLOAD;
        end
      end
      tfd_pkg::PH_PAYLOAD: begin
        res_o.valid = 1'b1;
        res_o.data  = is_mid ? ~b : b;
        res_o.last  = is_last;
        pay_cnt_d   = pay_cnt_q + 32'd1;
        if (is_last) begin
          trl_cnt_d = '0;
          phase_d   = tfd_pkg::PH_TRAILER;
        end
      end
      tfd_pkg::PH_TRAILER: begin
        trl_cnt_d = trl_inc;
        if (trl_inc == 4'(TAG_LEN)) begin
          trl_cnt_d = '0;
          tag_cnt_d = '0;
          phase_d   = tfd_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_d = tfd_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tfd_pkg::PH_HUNT;
      tag_cnt_q <= '0;
      hdr_cnt_q <= '0;
      size_q    <= '0;
      pay_cnt_q <= '0;
      trl_cnt_q <= '0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      tag_cnt_q <= tag_cnt_d;
      hdr_cnt_q <= hdr_cnt_d;
      size_q    <= size_d;
      pay_cnt_q <= pay_cnt_d;
      trl_cnt_q <= trl_cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tfd_out_stage.sv
// Result register of the deframer: holds one payload byte until taken.
`timescale 1ns / 1ps
`default_nettype none

module tfd_out_stage (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       advance_i,
  input  wire tfd_pkg::res_t              res_i,
  output logic                            slot_free_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [tfd_pkg::ByteW-1:0]       out_byte_o,
  output logic                            frame_last_o
);

  logic                      valid_q, valid_d;
  logic [tfd_pkg::ByteW-1:0] data_q;
  logic                      last_q;

  assign slot_free_o = !valid_q || out_ready_i;

  always_comb begin
    if (advance_i) begin
      valid_d = res_i.valid;
    end else begin
      valid_d = valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && res_i.valid) begin
      data_q <= res_i.data;
      last_q <= res_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = data_q;
  assign frame_last_o = last_q;

endmodule

`default_nettype wire

// File: rtl/core/tfd_checker.sv
// Port-level checks for the tagged frame deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tfd_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic [tfd_pkg::ByteW-1:0]  in_byte_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [tfd_pkg::ByteW-1:0]  out_byte_o,
  input wire logic                       frame_last_o
);

  // Result held while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(frame_last_o))
    else $error("output transaction changed while stalled");

  // Offered input byte held until taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_byte_i))
    else $error("input transaction changed while stalled");

  // No result during reset, and input ready.
  a_rst_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && in_ready_o)
    else $error("handshake active during reset");

  // Input backpressure only when the result slot is full and stalled.
  a_ready_cause: assert property (@(posedge clk_i)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // A new result in an empty slot is a byte that passed both registers unstalled.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output appeared with no input");

endmodule

bind tagged_frame_deframer tfd_checker u_tfd_checker (.*);

`default_nettype wire
